// ----- rtl/xibe_pkg.sv -----
// Shared types, constants and codes of the x86-64 instruction byte encoder.
package xibe_pkg;

    // Request limits.
    localparam int NUM_LANES       = 6;
    localparam int MAX_DESCRIPTORS = 6;
    localparam int MAX_BODY_BYTES  = 14;
    localparam int MAX_RESULTS     = 16;

    // Field and internal widths.
    localparam int DESC_W     = 11;
    localparam int LANE_BYTES = 8;
    localparam int LEN_W      = 4;
    localparam int OFF_W      = 6;
    localparam int IDX_W      = $clog2(MAX_RESULTS);
    localparam int CNT_W      = $clog2(MAX_RESULTS + 1);

    // Fixed byte values.
    localparam logic [7:0] PREFIX_OPSIZE = 8'h66;
    localparam logic [7:0] REX_R_BITS    = 8'h44;
    localparam logic [7:0] REX_B_BITS    = 8'h41;
    localparam logic [7:0] REX_W_BITS    = 8'h48;

    // ModRM fields.
    localparam logic [1:0] MOD_INDIRECT = 2'b00;
    localparam logic [1:0] MOD_DISP8    = 2'b01;
    localparam logic [1:0] MOD_DISP32   = 2'b10;
    localparam logic [1:0] MOD_REGISTER = 2'b11;
    localparam logic [2:0] RM_RBP       = 3'b101;

    // Addressing modes.
    localparam logic [1:0] MODE_DIRECT = 2'd1;
    localparam logic [1:0] MODE_RBP    = 2'd2;

    // Displacement limits.
    localparam logic [63:0] DISP8_MAX  = 64'd127;
    localparam logic [63:0] DISP32_MAX = 64'h0000_0000_7FFF_FFFF;

    // Descriptor kinds.
    typedef enum logic [2:0] {
        KIND_BYTE   = 3'd0,
        KIND_IMM    = 3'd1,
        KIND_MODRM  = 3'd2,
        KIND_DIGIT  = 3'd3,
        KIND_PLUS   = 3'd4,
        KIND_OPSIZE = 3'd5,
        KIND_REX    = 3'd6,
        KIND_REXW   = 3'd7
    } kind_t;

    // Error codes.
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_PLUSREG   = 2'd1,
        ERR_DISP      = 2'd2,
        ERR_MALFORMED = 2'd3
    } err_t;

    // Operands shared by all lanes.
    typedef struct packed {
        logic [3:0]  reg_num;
        logic [3:0]  rm_num;
        logic [1:0]  addr_mode;
        logic [63:0] imm;
        logic        disp_wide;
        logic        disp_bad;
    } operand_t;

    // What one descriptor lane contributes.
    typedef struct packed {
        logic [LEN_W-1:0]                len;
        logic [LEN_W-1:0]                chk_len;
        logic [LANE_BYTES-1:0][7:0]      bytes;
        logic                            put;
        logic                            plus;
        logic                            disp_bad;
        logic [7:0]                      rex;
        logic                            want_leg;
        logic                            want_rex;
    } lane_res_t;

    // Merged view of one request.
    typedef struct packed {
        err_t                            err;
        logic [CNT_W-1:0]                cnt;
        logic [1:0]                      head_cnt;
        logic [1:0][7:0]                 head;
        logic [NUM_LANES-1:0][CNT_W-1:0] pos;
    } merge_t;

endpackage

// ----- rtl/xibe_lane.sv -----
// One descriptor lane: turns a descriptor into its body bytes and flags.
module xibe_lane (
    input  logic [xibe_pkg::DESC_W-1:0] desc,
    input  logic                        on,
    input  xibe_pkg::operand_t          opnd,
    output xibe_pkg::lane_res_t         res
);
    import xibe_pkg::*;

    kind_t      kind;
    logic [7:0] val;
    logic [2:0] regfield;
    logic [7:0] modrm;

    // Decode the descriptor kind and build this lane's bytes.
    always_comb
    begin
        kind     = kind_t'(desc[10:8]);
        val      = desc[7:0];
        res      = '0;
        modrm    = '0;
        regfield = (kind == KIND_DIGIT) ? val[2:0] : opnd.reg_num[2:0];
        if (on)
        begin
            case (kind)
                KIND_BYTE:
                begin
                    res.put      = 1'b1;
                    res.len      = LEN_W'(1);
                    res.chk_len  = LEN_W'(1);
                    res.bytes[0] = val;
                end
                KIND_IMM:
                begin
                    res.put     = 1'b1;
                    res.len     = LEN_W'(1) << val[1:0];
                    res.chk_len = LEN_W'(1) << val[1:0];
                    res.bytes   = opnd.imm;
                end
                KIND_MODRM, KIND_DIGIT:
                begin
                    res.put = 1'b1;
                    if (kind == KIND_MODRM && opnd.reg_num[3])
                    begin
                        res.rex = REX_R_BITS;
                    end
                    if (opnd.addr_mode == MODE_RBP)
                    begin
                        // RBP-relative: ModRM followed by disp8 or disp32.
                        modrm = {opnd.disp_wide ? MOD_DISP32 : MOD_DISP8, regfield, RM_RBP};
                        res.bytes    = {24'd0, opnd.imm[31:0], modrm};
                        res.len      = opnd.disp_wide ? LEN_W'(5) : LEN_W'(2);
                        res.disp_bad = opnd.disp_bad;
                        res.chk_len  = opnd.disp_bad ? LEN_W'(1) : res.len;
                    end
                    else
                    begin
                        modrm = {(opnd.addr_mode == MODE_DIRECT) ? MOD_REGISTER : MOD_INDIRECT,
                                 regfield, opnd.rm_num[2:0]};
                        if (opnd.rm_num[3])
                        begin
                            res.rex = res.rex | REX_B_BITS;
                        end
                        res.bytes[0] = modrm;
                        res.len      = LEN_W'(1);
                        res.chk_len  = LEN_W'(1);
                    end
                end
                KIND_PLUS:
                begin
                    res.plus = 1'b1;
                end
                KIND_OPSIZE:
                begin
                    res.want_leg = 1'b1;
                end
                KIND_REX:
                begin
                    res.want_rex = 1'b1;
                end
                KIND_REXW:
                begin
                    res.want_rex = 1'b1;
                    res.rex      = REX_W_BITS;
                end
                default:
                begin
                    res = '0;
                end
            endcase
        end
    end

endmodule

// ----- rtl/xibe_merge.sv -----
// Merging stage: body offsets, first error, prefix bytes and byte count.
module xibe_merge (
    input  xibe_pkg::lane_res_t [xibe_pkg::NUM_LANES-1:0] lanes,
    input  logic [3:0]                                    reg_num,
    output xibe_pkg::merge_t                              m
);
    import xibe_pkg::*;

    logic [OFF_W-1:0]                off;
    logic [OFF_W-1:0]                total;
    logic [NUM_LANES-1:0][OFF_W-1:0] start;
    logic                            found;
    err_t                            lane_err;
    logic [7:0]                      rex;
    logic                            want_leg;
    logic                            want_rex;
    logic                            rex_on;

    always_comb
    begin
        off      = '0;
        found    = 1'b0;
        rex      = '0;
        want_leg = 1'b0;
        want_rex = 1'b0;
        m        = '0;
        m.err    = ERR_NONE;
        lane_err = ERR_NONE;

        // Walk the lanes in order; the first failing lane sets the error.
        for (int i = 0; i < NUM_LANES; i++)
        begin
            lane_err = ERR_NONE;
            if (lanes[i].plus)
            begin
                if (reg_num[3])
                begin
                    lane_err = ERR_PLUSREG;
                end
                else if (off == '0)
                begin
                    lane_err = ERR_MALFORMED;
                end
            end
            else if (lanes[i].put)
            begin
                if (off + OFF_W'(lanes[i].chk_len) > OFF_W'(MAX_BODY_BYTES))
                begin
                    lane_err = ERR_MALFORMED;
                end
                else if (lanes[i].disp_bad)
                begin
                    lane_err = ERR_DISP;
                end
            end
            if (!found && lane_err != ERR_NONE)
            begin
                m.err = lane_err;
                found = 1'b1;
            end
            start[i] = off;
            off      = off + OFF_W'(lanes[i].len);
            rex      = rex | lanes[i].rex;
            want_leg = want_leg | lanes[i].want_leg;
            want_rex = want_rex | lanes[i].want_rex;
        end

        // Prefix bytes: 0x66 first, then REX when requested and nonzero.
        rex_on     = want_rex && (rex != 8'd0);
        m.head_cnt = 2'(want_leg) + 2'(rex_on);
        m.head[0]  = want_leg ? PREFIX_OPSIZE : rex;
        m.head[1]  = rex;

        total = OFF_W'(m.head_cnt) + off;
        if (!found && (total == '0 || total > OFF_W'(MAX_RESULTS)))
        begin
            m.err = ERR_MALFORMED;
        end
        m.cnt = (m.err != ERR_NONE) ? CNT_W'(1) : CNT_W'(total);

        // Output position of each lane's first byte.
        for (int i = 0; i < NUM_LANES; i++)
        begin
            m.pos[i] = CNT_W'(start[i] + OFF_W'(m.head_cnt));
        end
    end

endmodule

// ----- rtl/xibe_serial.sv -----
// Byte assembly and output serializer that sends one byte per cycle.
module xibe_serial (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          load,
    input  xibe_pkg::merge_t                              m,
    input  xibe_pkg::lane_res_t [xibe_pkg::NUM_LANES-1:0] lanes,
    input  logic [3:0]                                    reg_num,
    output logic                                          hold,
    output logic                                          strobe,
    output logic [7:0]                                    out_byte,
    output logic                                          last,
    output logic [1:0]                                    error
);
    import xibe_pkg::*;

    logic [MAX_RESULTS-1:0][7:0] asm_bytes;
    logic [MAX_RESULTS-1:0][7:0] buf_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [IDX_W-1:0]            idx_reg;
    err_t                        err_reg;
    logic                        valid_reg;
    logic                        last_now;
    logic [7:0]                  b;
    logic [2:0]                  pc;
    logic [CNT_W:0]              diff;

    // Place prefix and lane bytes at their positions and apply +r additions.
    always_comb
    begin
        asm_bytes = '0;
        b         = '0;
        pc        = '0;
        diff      = '0;
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            b  = '0;
            pc = '0;
            if (k == 0 && m.head_cnt != 2'd0)
            begin
                b = m.head[0];
            end
            if (k == 1 && m.head_cnt == 2'd2)
            begin
                b = m.head[1];
            end
            for (int j = 0; j < NUM_LANES; j++)
            begin
                diff = (CNT_W+1)'(k) - {1'b0, m.pos[j]};
                if (!diff[CNT_W] && diff[CNT_W-1:0] < CNT_W'(lanes[j].len))
                begin
                    b = b | lanes[j].bytes[diff[$clog2(LANE_BYTES)-1:0]];
                end
                if (lanes[j].plus && m.pos[j] == CNT_W'(k + 1))
                begin
                    pc = pc + 3'd1;
                end
            end
            asm_bytes[k] = b + 8'(reg_num) * 8'(pc);
        end
        if (m.err != ERR_NONE)
        begin
            asm_bytes = '0;
        end
    end

    assign last_now = valid_reg && ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);
    assign hold     = valid_reg && !last_now;

    // Control: valid flag and byte index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (valid_reg)
        begin
            if (last_now)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // Payload: assembled bytes, count and error code.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= asm_bytes;
            cnt_reg <= m.cnt;
            err_reg <= m.err;
        end
    end

    assign strobe   = valid_reg;
    assign out_byte = buf_reg[idx_reg];
    assign last     = last_now;
    assign error    = err_reg;

endmodule

// ----- rtl/x86_64_instruction_byte_encoder.sv -----
// Top level: six descriptor lanes, a merging stage and the byte serializer.
// A taken start passes the lane result registers, the merge stage registers and the serializer
// buffer before its first byte is strobed. The single-byte output serializer sends one byte per
// cycle; it holds a request of 1 to 16 bytes, and loads the next one while the last byte goes out.
// Reset clears the valid flags of the lane, merge and serializer stages; no clearing pass.
// The receiver cannot stall: every strobed byte is taken in its cycle.
module x86_64_instruction_byte_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [10:0] desc_0,
    input  logic [10:0] desc_1,
    input  logic [10:0] desc_2,
    input  logic [10:0] desc_3,
    input  logic [10:0] desc_4,
    input  logic [10:0] desc_5,
    input  logic [2:0]  desc_count,
    input  logic [3:0]  reg_num,
    input  logic [3:0]  rm_num,
    input  logic [1:0]  addr_mode,
    input  logic [63:0] imm_value,
    output logic        strobe,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic [1:0]  error
);
    import xibe_pkg::*;

    logic [NUM_LANES-1:0][DESC_W-1:0] desc_arr;
    logic [3:0]                       eff_n;
    operand_t                         opnd;
    lane_res_t [NUM_LANES-1:0]        lane_out;

    logic                             lane_valid_reg;
    lane_res_t [NUM_LANES-1:0]        lane_reg;
    logic [3:0]                       lane_rnum_reg;

    merge_t                           merge_out;
    logic                             mrg_valid_reg;
    merge_t                           mrg_reg;
    lane_res_t [NUM_LANES-1:0]        mrg_lanes_reg;
    logic [3:0]                       mrg_rnum_reg;

    logic                             ser_hold;
    logic                             ser_load;
    logic                             mrg_free;
    logic                             lane_free;
    logic                             accept;

    // Shared operands and descriptor count limit.
    assign desc_arr = {desc_5, desc_4, desc_3, desc_2, desc_1, desc_0};
    assign eff_n    = ({1'b0, desc_count} > 4'(MAX_DESCRIPTORS)) ? 4'(MAX_DESCRIPTORS)
                                                                  : {1'b0, desc_count};
    assign opnd.reg_num   = reg_num;
    assign opnd.rm_num    = rm_num;
    assign opnd.addr_mode = addr_mode;
    assign opnd.imm       = imm_value;
    assign opnd.disp_wide = imm_value > DISP8_MAX;
    assign opnd.disp_bad  = imm_value > DISP32_MAX;

    // Descriptor lanes working side by side.
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        xibe_lane u_lane (
            .desc (desc_arr[i]),
            .on   (4'(i) < eff_n),
            .opnd (opnd),
            .res  (lane_out[i])
        );
    end

    // Pipeline flow control.
    assign ser_load  = mrg_valid_reg && !ser_hold;
    assign mrg_free  = !mrg_valid_reg || ser_load;
    assign lane_free = !lane_valid_reg || mrg_free;
    assign busy      = !lane_free;
    assign accept    = start && lane_free;

    // Lane result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
        end
        else if (lane_free)
        begin
            lane_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lane_reg      <= lane_out;
            lane_rnum_reg <= reg_num;
        end
    end

    xibe_merge u_merge (
        .lanes   (lane_reg),
        .reg_num (lane_rnum_reg),
        .m       (merge_out)
    );

    // Merge stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mrg_valid_reg <= 1'b0;
        end
        else if (mrg_free)
        begin
            mrg_valid_reg <= lane_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mrg_free && lane_valid_reg)
        begin
            mrg_reg       <= merge_out;
            mrg_lanes_reg <= lane_reg;
            mrg_rnum_reg  <= lane_rnum_reg;
        end
    end

    xibe_serial u_serial (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (ser_load),
        .m        (mrg_reg),
        .lanes    (mrg_lanes_reg),
        .reg_num  (mrg_rnum_reg),
        .hold     (ser_hold),
        .strobe   (strobe),
        .out_byte (out_byte),
        .last     (last),
        .error    (error)
    );

`ifndef SYNTHESIS
    // An error transaction is a single zero byte marked last.
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && error != 2'd0) |-> (last && out_byte == 8'd0))
        else $error("error result is not a single zero byte");

    // A result sequence continues until its last byte.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("result bytes stopped before the last byte");

    // Error code stays fixed within one result sequence.
    a_err_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> $stable(error))
        else $error("error code changed inside a result sequence");

    // The input side is free whenever no request waits in the lane stage.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (lane_valid_reg && mrg_valid_reg && ser_hold))
        else $error("busy raised without a full pipeline");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the x86-64 instruction byte encoder: directed and random requests.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import xibe_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 200;
    localparam int MAX_PRINTS   = 40;

    // One instruction request as the driver presents it.
    typedef struct {
        logic [NUM_LANES-1:0][DESC_W-1:0] desc;
        logic [2:0]  count;
        logic [3:0]  reg_num;
        logic [3:0]  rm_num;
        logic [1:0]  addr_mode;
        logic [63:0] imm;
        int          gap;
    } insn_req_t;

    // One expected machine code byte.
    typedef struct {
        logic [7:0] val;
        logic       last;
        err_t       err;
    } code_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [10:0] desc_0 = '0;
    logic [10:0] desc_1 = '0;
    logic [10:0] desc_2 = '0;
    logic [10:0] desc_3 = '0;
    logic [10:0] desc_4 = '0;
    logic [10:0] desc_5 = '0;
    logic [2:0]  desc_count = '0;
    logic [3:0]  reg_num = '0;
    logic [3:0]  rm_num = '0;
    logic [1:0]  addr_mode = '0;
    logic [63:0] imm_value = '0;
    logic        strobe;
    logic [7:0]  out_byte;
    logic        last;
    logic [1:0]  error;

    insn_req_t  pending_reqs [$];
    code_byte_t code_due [$];
    logic [7:0] enc_body [$];
    insn_req_t  cur_req;
    insn_req_t  next_req;
    code_byte_t got_due;
    logic       have_next = 1'b0;
    logic       no_idle = 1'b0;
    int         idle_left = 0;
    int         fail_count = 0;
    int         cycle_count = 0;

    x86_64_instruction_byte_encoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .desc_0     (desc_0),
        .desc_1     (desc_1),
        .desc_2     (desc_2),
        .desc_3     (desc_3),
        .desc_4     (desc_4),
        .desc_5     (desc_5),
        .desc_count (desc_count),
        .reg_num    (reg_num),
        .rm_num     (rm_num),
        .addr_mode  (addr_mode),
        .imm_value  (imm_value),
        .strobe     (strobe),
        .out_byte   (out_byte),
        .last       (last),
        .error      (error)
    );

    // Clock with a 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Print one line per mismatch, up to a cap, and count them all.
    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic logic [10:0] dsc(input kind_t k, input logic [7:0] v);
        return {k, v};
    endfunction

    // Append nb little-endian bytes of v to the body; returns 0 on overflow.
    function automatic bit body_put(input logic [63:0] v, input int nb);
        if (enc_body.size() + nb > MAX_BODY_BYTES)
            return 1'b0;
        for (int k = 0; k < nb; k++)
            enc_body.push_back(8'(v >> (8 * k)));
        return 1'b1;
    endfunction

    // Work out the byte stream of one request and queue it as expected.
    function automatic void encode_instruction(input insn_req_t r);
        logic [7:0] rex_bits;
        logic       want_opsize;
        logic       want_rex;
        logic [10:0] d;
        kind_t      kind;
        logic [7:0] val;
        logic [2:0] regfield;
        logic [7:0] modrm;
        err_t       fault;
        logic [7:0] code [$];
        int         n;
        rex_bits = '0;
        want_opsize = 1'b0;
        want_rex = 1'b0;
        fault = ERR_NONE;
        enc_body.delete();
        n = (r.count > MAX_DESCRIPTORS) ? MAX_DESCRIPTORS : int'(r.count);
        for (int i = 0; i < n && fault == ERR_NONE; i++)
        begin
            d = r.desc[i];
            kind = kind_t'(d[10:8]);
            val = d[7:0];
            case (kind)
                KIND_BYTE:
                begin
                    if (!body_put(64'(val), 1))
                        fault = ERR_MALFORMED;
                end
                KIND_IMM:
                begin
                    if (!body_put(r.imm, 1 << val[1:0]))
                        fault = ERR_MALFORMED;
                end
                KIND_MODRM, KIND_DIGIT:
                begin
                    // A digit takes the reg field and never sets REX.R.
                    if (kind == KIND_DIGIT)
                        regfield = val[2:0];
                    else
                    begin
                        regfield = r.reg_num[2:0];
                        if (r.reg_num[3])
                            rex_bits |= REX_R_BITS;
                    end
                    if (r.addr_mode == MODE_RBP)
                    begin
                        modrm = {(r.imm > DISP8_MAX) ? MOD_DISP32 : MOD_DISP8, regfield, RM_RBP};
                        if (!body_put(64'(modrm), 1))
                            fault = ERR_MALFORMED;
                        else if (r.imm > DISP32_MAX)
                            fault = ERR_DISP;
                        else if (!body_put(r.imm, (r.imm > DISP8_MAX) ? 4 : 1))
                            fault = ERR_MALFORMED;
                    end
                    else
                    begin
                        // Mode three falls back to register indirect.
                        modrm = {(r.addr_mode == MODE_DIRECT) ? MOD_REGISTER : MOD_INDIRECT,
                                 regfield, r.rm_num[2:0]};
                        if (r.rm_num[3])
                            rex_bits |= REX_B_BITS;
                        if (!body_put(64'(modrm), 1))
                            fault = ERR_MALFORMED;
                    end
                end
                KIND_PLUS:
                begin
                    if (r.reg_num[3])
                        fault = ERR_PLUSREG;
                    else if (enc_body.size() == 0)
                        fault = ERR_MALFORMED;
                    else
                        enc_body[enc_body.size() - 1] += 8'(r.reg_num);
                end
                KIND_OPSIZE:
                    want_opsize = 1'b1;
                KIND_REX:
                    want_rex = 1'b1;
                default:
                begin
                    want_rex = 1'b1;
                    rex_bits |= REX_W_BITS;
                end
            endcase
        end

        // Assemble prefix, REX and body, or a lone error result.
        if (fault == ERR_NONE)
        begin
            if (want_opsize)
                code.push_back(PREFIX_OPSIZE);
            if (want_rex && rex_bits != 8'h00)
                code.push_back(rex_bits);
            if (code.size() + enc_body.size() == 0
                || code.size() + enc_body.size() > MAX_RESULTS)
                fault = ERR_MALFORMED;
        end
        if (fault != ERR_NONE)
            code_due.push_back('{val: 8'h00, last: 1'b1, err: fault});
        else
        begin
            foreach (enc_body[k])
                code.push_back(enc_body[k]);
            foreach (code[k])
                code_due.push_back('{val: code[k], last: (k == code.size() - 1), err: ERR_NONE});
        end
    endfunction

    // Queue a request with a drawn idle gap before it.
    function automatic void add_req(input int cnt, input int rg, input int rmv, input int mode,
                                    input logic [63:0] imm, input logic [10:0] d0,
                                    input logic [10:0] d1, input logic [10:0] d2,
                                    input logic [10:0] d3, input logic [10:0] d4,
                                    input logic [10:0] d5);
        insn_req_t r;
        r.desc = {d5, d4, d3, d2, d1, d0};
        r.count = 3'(cnt);
        r.reg_num = 4'(rg);
        r.rm_num = 4'(rmv);
        r.addr_mode = 2'(mode);
        r.imm = imm;
        r.gap = no_idle ? 0 : $urandom_range(0, 18);
        pending_reqs.push_back(r);
    endfunction

    // Random request: mostly a plausible instruction template, sometimes pure noise.
    function automatic insn_req_t random_request();
        insn_req_t r;
        int n;
        int shape;
        for (int i = 0; i < NUM_LANES; i++)
            r.desc[i] = 11'($urandom);
        r.count = 3'($urandom_range(0, 7));
        r.reg_num = 4'($urandom);
        r.rm_num = 4'($urandom);
        r.addr_mode = 2'($urandom);
        case ($urandom_range(0, 3))
            0: r.imm = 64'($urandom_range(0, 127));
            1: r.imm = 64'($urandom_range(128, 32'h7FFF_FFFF));
            2: r.imm = {$urandom, $urandom};
            default: r.imm = ($urandom_range(0, 1) ? DISP8_MAX : DISP32_MAX)
                             + 64'($urandom_range(0, 1));
        endcase
        if ($urandom_range(0, 99) < 80)
        begin
            n = 0;
            if ($urandom_range(0, 2) == 0)
            begin
                r.desc[n] = dsc(KIND_OPSIZE, 8'($urandom));
                n++;
            end
            shape = $urandom_range(0, 2);
            if (shape != 0)
            begin
                r.desc[n] = dsc((shape == 1) ? KIND_REX : KIND_REXW, 8'($urandom));
                n++;
            end
            r.desc[n] = dsc(KIND_BYTE, 8'($urandom));
            n++;
            case ($urandom_range(0, 4))
                0: begin r.desc[n] = dsc(KIND_MODRM, 8'($urandom)); n++; end
                1: begin r.desc[n] = dsc(KIND_DIGIT, 8'($urandom)); n++; end
                2:
                begin
                    r.desc[n] = dsc(KIND_PLUS, 8'($urandom));
                    r.reg_num[3] = ($urandom_range(0, 4) == 0);
                    n++;
                end
                3: begin r.desc[n] = dsc(KIND_IMM, 8'($urandom)); n++; end
                default: ;
            endcase
            if ($urandom_range(0, 1) == 1)
            begin
                r.desc[n] = dsc(KIND_IMM, 8'($urandom));
                n++;
            end
            r.count = 3'(n);
        end
        r.gap = no_idle ? 0 : $urandom_range(0, 18);
        return r;
    endfunction

    // Driver: presents queued requests and predicts each accepted transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            have_next = 1'b0;
            idle_left = 0;
        end
        else
        begin
            if (start && !busy)
                encode_instruction(cur_req);
            if (!start || !busy)
            begin
                if (!have_next && pending_reqs.size() != 0)
                begin
                    next_req = pending_reqs.pop_front();
                    have_next = 1'b1;
                    idle_left = next_req.gap;
                end
                if (have_next && idle_left == 0)
                begin
                    desc_0     <= next_req.desc[0];
                    desc_1     <= next_req.desc[1];
                    desc_2     <= next_req.desc[2];
                    desc_3     <= next_req.desc[3];
                    desc_4     <= next_req.desc[4];
                    desc_5     <= next_req.desc[5];
                    desc_count <= next_req.count;
                    reg_num    <= next_req.reg_num;
                    rm_num     <= next_req.rm_num;
                    addr_mode  <= next_req.addr_mode;
                    imm_value  <= next_req.imm;
                    start      <= 1'b1;
                    cur_req = next_req;
                    have_next = 1'b0;
                end
                else
                begin
                    if (have_next)
                        idle_left--;
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each strobed byte with the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (code_due.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h last %0b error %0d",
                                          out_byte, last, error));
            else
            begin
                got_due = code_due.pop_front();
                if (out_byte !== got_due.val)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_byte, got_due.val));
                if (last !== got_due.last)
                    report_mismatch($sformatf("last %0b, expected %0b", last, got_due.last));
                if (error !== got_due.err)
                    report_mismatch($sformatf("error %0d, expected %0d", error, got_due.err));
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("x86_64_instruction_byte_encoder test failed");
            $finish;
        end
    end

    initial
    begin
        // Directed requests: field extremes, every descriptor kind and the error cases.
        add_req(1, 0, 0, 0, 64'h0, dsc(KIND_BYTE, 8'h90), 0, 0, 0, 0, 0);
        add_req(0, 0, 0, 0, 64'h0, dsc(KIND_BYTE, 8'h90), 0, 0, 0, 0, 0);
        add_req(1, 0, 0, 0, 64'h0, dsc(KIND_OPSIZE, 8'h00), 0, 0, 0, 0, 0);
        add_req(1, 0, 0, 0, 64'h0, dsc(KIND_REX, 8'hFF), 0, 0, 0, 0, 0);
        add_req(3, 15, 9, 1, 64'h0, dsc(KIND_REXW, 8'h00), dsc(KIND_BYTE, 8'h89),
                dsc(KIND_MODRM, 8'h00), 0, 0, 0);
        add_req(3, 3, 2, 0, 64'h0, dsc(KIND_REX, 8'h00), dsc(KIND_BYTE, 8'h88),
                dsc(KIND_MODRM, 8'h00), 0, 0, 0);
        // Move of a full 64-bit immediate into a +r register.
        add_req(4, 7, 0, 0, 64'hFEDC_BA98_7654_3210, dsc(KIND_REXW, 8'h00),
                dsc(KIND_BYTE, 8'hB8), dsc(KIND_PLUS, 8'h00), dsc(KIND_IMM, 8'h03), 0, 0);
        add_req(3, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, dsc(KIND_OPSIZE, 8'hFF),
                dsc(KIND_BYTE, 8'h05), dsc(KIND_IMM, 8'hFD), 0, 0, 0);
        add_req(2, 0, 0, 0, 64'h1234_5678_9ABC_DEF0, dsc(KIND_BYTE, 8'h05),
                dsc(KIND_IMM, 8'h02), 0, 0, 0, 0);
        // A +r with nothing before it, and a +r register above 7.
        add_req(2, 3, 0, 0, 64'h0, dsc(KIND_PLUS, 8'h00), dsc(KIND_BYTE, 8'h50), 0, 0, 0, 0);
        add_req(2, 8, 0, 0, 64'h0, dsc(KIND_PLUS, 8'h00), dsc(KIND_BYTE, 8'h50), 0, 0, 0, 0);
        add_req(2, 7, 0, 0, 64'h0, dsc(KIND_BYTE, 8'hFF), dsc(KIND_PLUS, 8'hFF), 0, 0, 0, 0);
        // RBP-relative displacements around the disp8 and disp32 limits.
        add_req(2, 1, 0, 2, 64'd0, dsc(KIND_BYTE, 8'h8B), dsc(KIND_MODRM, 8'h00), 0, 0, 0, 0);
        add_req(2, 1, 0, 2, 64'd127, dsc(KIND_BYTE, 8'h8B), dsc(KIND_MODRM, 8'h00), 0, 0, 0, 0);
        add_req(2, 1, 0, 2, 64'd128, dsc(KIND_BYTE, 8'h8B), dsc(KIND_MODRM, 8'h00), 0, 0, 0, 0);
        add_req(2, 1, 0, 2, 64'h7FFF_FFFF, dsc(KIND_BYTE, 8'h8B), dsc(KIND_MODRM, 8'h00),
                0, 0, 0, 0);
        add_req(2, 1, 0, 2, 64'h8000_0000, dsc(KIND_BYTE, 8'h8B), dsc(KIND_MODRM, 8'h00),
                0, 0, 0, 0);
        add_req(2, 1, 0, 2, 64'hFFFF_FFFF_FFFF_FFFF, dsc(KIND_BYTE, 8'h8B),
                dsc(KIND_MODRM, 8'h00), 0, 0, 0, 0);
        // A digit in RBP mode ignores a high reg number; a high register with REX.R.
        add_req(4, 12, 15, 2, 64'd200, dsc(KIND_REX, 8'h00), dsc(KIND_BYTE, 8'h81),
                dsc(KIND_DIGIT, 8'hFF), dsc(KIND_IMM, 8'h02), 0, 0);
        add_req(3, 15, 15, 2, 64'd4, dsc(KIND_REX, 8'h00), dsc(KIND_BYTE, 8'h89),
                dsc(KIND_MODRM, 8'h00), 0, 0, 0);
        add_req(4, 0, 13, 1, 64'h7F, dsc(KIND_REXW, 8'h00), dsc(KIND_BYTE, 8'hC1),
                dsc(KIND_DIGIT, 8'h04), dsc(KIND_IMM, 8'h00), 0, 0);
        add_req(2, 6, 5, 3, 64'h0, dsc(KIND_BYTE, 8'h8B), dsc(KIND_MODRM, 8'h00), 0, 0, 0, 0);
        // Longest legal encoding, then body overflows.
        add_req(5, 0, 0, 0, 64'hA5A5_5A5A_C3C3_3C3C, dsc(KIND_OPSIZE, 8'h00),
                dsc(KIND_REXW, 8'h00), dsc(KIND_IMM, 8'h03), dsc(KIND_IMM, 8'h02),
                dsc(KIND_IMM, 8'h01), 0);
        add_req(4, 0, 0, 0, 64'h1, dsc(KIND_IMM, 8'h03), dsc(KIND_IMM, 8'h02),
                dsc(KIND_IMM, 8'h01), dsc(KIND_BYTE, 8'h00), 0, 0);
        add_req(2, 0, 0, 0, 64'h1, dsc(KIND_IMM, 8'h03), dsc(KIND_IMM, 8'h03), 0, 0, 0, 0);
        add_req(3, 0, 0, 2, 64'h100, dsc(KIND_IMM, 8'h03), dsc(KIND_IMM, 8'h02),
                dsc(KIND_MODRM, 8'h00), 0, 0, 0);
        // Count above the lane number, and all lanes at their top value.
        add_req(7, 0, 0, 0, 64'h0, dsc(KIND_BYTE, 8'h01), dsc(KIND_BYTE, 8'h02),
                dsc(KIND_BYTE, 8'h03), dsc(KIND_BYTE, 8'h04), dsc(KIND_BYTE, 8'h05),
                dsc(KIND_BYTE, 8'h06));
        add_req(6, 15, 15, 3, 64'hFFFF_FFFF_FFFF_FFFF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF,
                11'h7FF, 11'h7FF);

        // Random requests, with stretches of back-to-back starts.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = ((i / 25) % 3 == 1);
            pending_reqs.push_back(random_request());
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all requests taken and every expected byte seen.
        while (pending_reqs.size() != 0 || have_next || start || code_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (code_due.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never arrived", code_due.size()));

        if (fail_count == 0)
            $display("x86_64_instruction_byte_encoder test passed");
        else
            $display("x86_64_instruction_byte_encoder test failed");
        $finish;
    end

endmodule
